FILE: design/dtq_pkg.sv
// Package for the deadline timer queue: sizes, operation and result codes,
// and the structs passed between the sequencer, the timer table and the select unit.
// No dependencies.
package dtq_pkg;

  // Table size and field widths.
  localparam int NUM_TIMERS = 16;
  localparam int TICK_BITS  = 32;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int STAMP_W    = 16;
  localparam int MAX_OUT    = 16;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam int FUNC_W     = 2;
  localparam int ID_W       = 4;
  localparam int PERIOD_W   = 32;
  localparam int KIND_W     = 2;

  // A timer is due when (now - deadline) wraps to less than this value.
  localparam logic [TICK_BITS-1:0] TICK_HALF = {1'b0, {(TICK_BITS-1){1'b1}}};

  // Operation codes carried by a request.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CONFIG = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_STOP   = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  // Result codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_NONE    = 2'd2
  } kind_e;

  // One update of the timer table; at most one enable is set in a cycle.
  typedef struct packed {
    logic                 cfg_we;
    logic                 start_en;
    logic                 stop_en;
    logic                 expire_en;
    logic [IDX_W-1:0]     slot;
    logic [TICK_BITS-1:0] period;
    logic                 periodic;
    logic [TICK_BITS-1:0] now;
  } tbl_cmd_t;

  // Verdict of the shared compare unit on one scanned slot.
  typedef struct packed {
    logic                 due;
    logic                 take;
    logic [TICK_BITS-1:0] lag;
    logic [STAMP_W-1:0]   age;
  } sel_res_t;

endpackage

FILE: design/dtq_if.sv
// Valid/ready channel interfaces for the deadline timer queue: request and result.
// Depends on dtq_pkg for field widths.
interface dtq_req_if;
  import dtq_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ID_W-1:0]     timer_id;
  logic [PERIOD_W-1:0] period;
  logic                periodic;
  logic [PERIOD_W-1:0] tick_now;

  modport source (output valid, func, timer_id, period, periodic, tick_now,
                  input ready);
  modport sink   (input valid, func, timer_id, period, periodic, tick_now,
                  output ready);
endinterface

interface dtq_rsp_if;
  import dtq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ID_W-1:0]   expired_id;
  logic              last;

  modport source (output valid, event_kind, expired_id, last, input ready);
  modport sink   (input valid, event_kind, expired_id, last, output ready);
endinterface

FILE: design/dtq_select_unit.sv
// Shared due test and ordering compare used once per scan cycle.
// Depends on dtq_pkg.
module dtq_select_unit (
  input  logic [dtq_pkg::TICK_BITS-1:0] now_i,
  input  logic [dtq_pkg::TICK_BITS-1:0] deadline_i,
  input  logic [dtq_pkg::STAMP_W-1:0]   snap_i,
  input  logic [dtq_pkg::STAMP_W-1:0]   stamp_i,
  input  logic                          active_i,
  input  logic                          due_bit_i,
  input  logic                          first_pass_i,
  input  logic                          found_i,
  input  logic [dtq_pkg::TICK_BITS-1:0] best_lag_i,
  input  logic [dtq_pkg::STAMP_W-1:0]   best_age_i,
  output dtq_pkg::sel_res_t             res_o
);
  import dtq_pkg::*;

  logic [TICK_BITS-1:0] lag;
  logic [STAMP_W-1:0]   age;
  logic                 due;

  // Lateness and start age, both wrapping.
  assign lag = now_i - deadline_i;
  assign age = snap_i - stamp_i;

  // The first pass decides the due set; later passes reuse it.
  assign due = first_pass_i ? (active_i && (lag < TICK_HALF)) : due_bit_i;

  // Earliest deadline (greatest lateness) wins; on a tie the older start wins; the scan order
  // keeps the lowest slot on a full tie.
  always_comb begin
    res_o.due  = due;
    res_o.lag  = lag;
    res_o.age  = age;
    res_o.take = due && (!found_i || (lag > best_lag_i) ||
                         ((lag == best_lag_i) && (age > best_age_i)));
  end

endmodule

FILE: design/dtq_timer_table.sv
// Timer table: period, deadline, active, periodic and start stamp per slot,
// plus the start stamp counter. Depends on dtq_pkg.
module dtq_timer_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtq_pkg::tbl_cmd_t             cmd_i,
  input  logic [dtq_pkg::IDX_W-1:0]     rd_idx_i,
  output logic [dtq_pkg::TICK_BITS-1:0] rd_deadline_o,
  output logic [dtq_pkg::STAMP_W-1:0]   rd_stamp_o,
  output logic                          rd_active_o,
  output logic [dtq_pkg::STAMP_W-1:0]   stamp_cnt_o
);
  import dtq_pkg::*;

  logic [TICK_BITS-1:0]  period_q   [NUM_TIMERS];
  logic [TICK_BITS-1:0]  deadline_q [NUM_TIMERS];
  logic [STAMP_W-1:0]    stamp_q    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active_q;
  logic [NUM_TIMERS-1:0] periodic_q;
  logic [STAMP_W-1:0]    cnt_q;
  logic                  arm;
  logic                  disarm;

  // An expiry rearms a periodic timer and disarms a one-shot one.
  assign arm    = cmd_i.start_en || (cmd_i.expire_en && periodic_q[cmd_i.slot]);
  assign disarm = cmd_i.stop_en || (cmd_i.expire_en && !periodic_q[cmd_i.slot]);

  // Table updates, one slot per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        period_q[i]   <= '0;
        deadline_q[i] <= '0;
        stamp_q[i]    <= '0;
      end
      active_q   <= '0;
      periodic_q <= '0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.cfg_we) begin
        period_q[cmd_i.slot]   <= cmd_i.period;
        periodic_q[cmd_i.slot] <= cmd_i.periodic;
        active_q[cmd_i.slot]   <= 1'b0;
        deadline_q[cmd_i.slot] <= '0;
      end
      if (arm) begin
        deadline_q[cmd_i.slot] <= cmd_i.now + period_q[cmd_i.slot];
        active_q[cmd_i.slot]   <= 1'b1;
        stamp_q[cmd_i.slot]    <= cnt_q;
        cnt_q                  <= cnt_q + 1'b1;
      end
      if (disarm) begin
        active_q[cmd_i.slot] <= 1'b0;
      end
    end
  end

  // Scan read port.
  assign rd_deadline_o = deadline_q[rd_idx_i];
  assign rd_stamp_o    = stamp_q[rd_idx_i];
  assign rd_active_o   = active_q[rd_idx_i];
  assign stamp_cnt_o   = cnt_q;

endmodule

FILE: design/deadline_timer_queue.sv
// Top level of the deadline timer queue: request decode, scan sequencer and
// result register. Depends on dtq_pkg, dtq_if, dtq_timer_table and dtq_select_unit.
//
// Configure, start and stop requests each return one acknowledge. A tick
// check walks the timer table with a single compare unit, one slot per
// cycle (the last slot of a pass waits while the result register is busy):
// each pass finds the next due timer in deadline order (oldest start first
// on equal deadlines), loads it into the result register and rearms or
// disarms it. A tick returns at most MAX_OUT results. The block takes no
// new request while a tick check is running; the next request can be
// accepted in the cycle after the last result is loaded, as soon as the
// result register is free.
module deadline_timer_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtq_req_if.sink   req_i,
  dtq_rsp_if.source rsp_o
);
  import dtq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      scan_idx_q, scan_idx_d;
  logic                  first_q, first_d;
  logic [NUM_TIMERS-1:0] due_q, due_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      best_q, best_d;
  logic [TICK_BITS-1:0]  best_lag_q, best_lag_d;
  logic [STAMP_W-1:0]    best_age_q, best_age_d;
  logic [TICK_BITS-1:0]  now_q, now_d;
  logic [STAMP_W-1:0]    snap_q, snap_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  rsp_valid_q, rsp_valid_d;
  kind_e                 rsp_kind_q, rsp_kind_d;
  logic [ID_W-1:0]       rsp_id_q, rsp_id_d;
  logic                  rsp_last_q, rsp_last_d;

  logic                  out_free;
  logic                  req_fire;
  logic                  in_range;
  logic [IDX_W-1:0]      in_slot;
  logic                  scanning;
  logic                  end_pass;
  logic                  emit;
  logic                  found_n;
  logic [IDX_W-1:0]      best_n;
  logic [NUM_TIMERS-1:0] due_new;
  logic [NUM_TIMERS-1:0] best_mask;
  logic [NUM_TIMERS-1:0] due_rem;
  logic                  last_n;
  logic [TICK_BITS-1:0]  rd_deadline;
  logic [STAMP_W-1:0]    rd_stamp;
  logic                  rd_active;
  logic [STAMP_W-1:0]    stamp_cnt;
  tbl_cmd_t              cmd;
  sel_res_t              sel;

  // Handshake and request decode.
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_range    = int'(req_i.timer_id) < NUM_TIMERS;
  assign in_slot     = IDX_W'(req_i.timer_id);
  assign scanning    = (state_q == ST_SCAN);

  // Timer storage.
  dtq_timer_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_idx_i     (scan_idx_q),
    .rd_deadline_o(rd_deadline),
    .rd_stamp_o   (rd_stamp),
    .rd_active_o  (rd_active),
    .stamp_cnt_o  (stamp_cnt)
  );

  // Shared compare unit, fed by the slot under scan.
  dtq_select_unit u_select (
    .now_i       (now_q),
    .deadline_i  (rd_deadline),
    .snap_i      (snap_q),
    .stamp_i     (rd_stamp),
    .active_i    (rd_active),
    .due_bit_i   (due_q[scan_idx_q]),
    .first_pass_i(first_q),
    .found_i     (found_q),
    .best_lag_i  (best_lag_q),
    .best_age_i  (best_age_q),
    .res_o       (sel)
  );

  // Running best of the current pass, including this cycle's slot.
  always_comb begin
    due_new             = due_q;
    due_new[scan_idx_q] = sel.due;
  end

  assign found_n   = found_q || sel.take;
  assign best_n    = sel.take ? scan_idx_q : best_q;
  assign best_mask = {{(NUM_TIMERS-1){1'b0}}, 1'b1} << best_n;
  assign due_rem   = due_new & ~best_mask;
  assign last_n    = !(|due_rem) || (cnt_q == CNT_W'(MAX_OUT - 1));
  assign end_pass  = (scan_idx_q == IDX_W'(NUM_TIMERS - 1));
  assign emit      = scanning && end_pass && out_free && found_n;

  // Table command: a request in idle, an expiry at the end of a pass.
  always_comb begin
    cmd.cfg_we    = req_fire && in_range && (req_i.func == FUNC_CONFIG);
    cmd.start_en  = req_fire && in_range && (req_i.func == FUNC_START);
    cmd.stop_en   = req_fire && in_range && (req_i.func == FUNC_STOP);
    cmd.expire_en = emit;
    cmd.slot      = scanning ? best_n : in_slot;
    cmd.period    = req_i.period[TICK_BITS-1:0];
    cmd.periodic  = req_i.periodic;
    cmd.now       = scanning ? now_q : req_i.tick_now[TICK_BITS-1:0];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    scan_idx_d  = scan_idx_q;
    first_d     = first_q;
    due_d       = due_q;
    found_d     = found_q;
    best_d      = best_q;
    best_lag_d  = best_lag_q;
    best_age_d  = best_age_q;
    now_d       = now_q;
    snap_d      = snap_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_kind_d  = rsp_kind_q;
    rsp_id_d    = rsp_id_q;
    rsp_last_d  = rsp_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.func == FUNC_TICK) begin
            state_d    = ST_SCAN;
            scan_idx_d = '0;
            first_d    = 1'b1;
            found_d    = 1'b0;
            due_d      = '0;
            now_d      = req_i.tick_now[TICK_BITS-1:0];
            snap_d     = stamp_cnt;
            id_d       = req_i.timer_id;
            cnt_d      = '0;
          end else begin
            rsp_valid_d = 1'b1;
            rsp_kind_d  = KIND_ACK;
            rsp_id_d    = req_i.timer_id;
            rsp_last_d  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!end_pass) begin
          scan_idx_d = scan_idx_q + 1'b1;
          due_d      = due_new;
          found_d    = found_n;
          best_d     = best_n;
          if (sel.take) begin
            best_lag_d = sel.lag;
            best_age_d = sel.age;
          end
        end else if (out_free) begin
          rsp_valid_d = 1'b1;
          if (found_n) begin
            rsp_kind_d = KIND_EXPIRED;
            rsp_id_d   = ID_W'(best_n);
            rsp_last_d = last_n;
            due_d      = due_rem;
            cnt_d      = cnt_q + 1'b1;
            scan_idx_d = '0;
            first_d    = 1'b0;
            found_d    = 1'b0;
            if (last_n) begin
              state_d = ST_IDLE;
            end
          end else begin
            rsp_kind_d = KIND_NONE;
            rsp_id_d   = id_q;
            rsp_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_idx_q  <= '0;
      first_q     <= 1'b0;
      due_q       <= '0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      first_q     <= first_d;
      due_q       <= due_d;
      found_q     <= found_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_lag_q <= best_lag_d;
    best_age_q <= best_age_d;
    now_q      <= now_d;
    snap_q     <= snap_d;
    id_q       <= id_d;
    rsp_kind_q <= rsp_kind_d;
    rsp_id_q   <= rsp_id_d;
    rsp_last_q <= rsp_last_d;
  end

  // Result port.
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.event_kind = rsp_kind_q;
  assign rsp_o.expired_id = rsp_id_q;
  assign rsp_o.last       = rsp_last_q;

  // The best candidate of a pass is always a member of the due set.
  a_best_is_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scanning && found_q) |-> due_q[best_q])
    else $error("best candidate is not in the due set");

  // An accepted tick check always starts a scan.
  a_tick_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_i.func == FUNC_TICK)) |=> (state_q == ST_SCAN))
    else $error("tick check did not start a scan");

  // Acknowledge and nothing-due results are single and final.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_kind_q != KIND_EXPIRED)) |-> rsp_last_q)
    else $error("single result without last");

  // No more than MAX_OUT expiries are emitted by one tick.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_OUT))
    else $error("expiry count exceeds limit");

endmodule
